// ===== hw/rtl/kcm_pkg.sv =====
// Shared types and constants for the k-closest-to-median block.
`timescale 1ns / 1ps

package kcm_pkg;

   // Default capacity of the sorting chain.
   localparam int MAX_ITEMS_DEFAULT = 64;

   // Width and reset value of the nearest-count register.
   localparam int COUNT_W = 6;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd1;

   // One input beat.
   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               set_end;
   } req_data_type;

   // One result beat.
   typedef struct packed {
      logic signed [31:0] near_value;
      logic [31:0]        gap;
      logic               run_end;
   } rsp_data_type;

   // Operation applied to every cell of the chain in the same cycle.
   typedef struct packed {
      logic load;   // insert the broadcast value in sorted position
      logic drain;  // every cell takes the value of its right neighbor
      logic clear;  // drop the whole contents
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/kcm_sort_cell.sv =====
// One cell of the sorting insertion chain.
`timescale 1ns / 1ps

module kcm_sort_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  kcm_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]    new_value,
   input  logic signed [31:0]    prev_value,
   input  logic                  prev_valid,
   input  logic                  prev_gt,
   input  logic signed [31:0]    next_value,
   input  logic                  next_valid,
   output logic signed [31:0]    value,
   output logic                  valid,
   output logic                  gt
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;

   // The cell holds a value larger than the one being inserted.
   assign gt = valid_ff && (value_ff > new_value);

   // Insert shifts the larger values one place right; drain shifts toward cell 0.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.load) begin
         if (gt || (prev_valid && !valid_ff)) begin
            value_in = prev_gt ? prev_value : new_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.drain) begin
         value_in = next_value;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== hw/rtl/kcm_select.sv =====
// Sorted set memory and the two-cursor walk that emits the nearest values.
`timescale 1ns / 1ps

module kcm_select #(
   parameter int MAX_ITEMS = kcm_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_ITEMS)-1:0]        wr_addr,
   input  logic signed [31:0]                  wr_data,
   input  logic                                start,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]      set_size,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]      take_count,
   input  logic signed [31:0]                  median,
   output logic                                busy,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kcm_pkg::rsp_data_type               rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_PICK  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         size_ff, size_in;
   logic [CW-1:0]         remain_ff, remain_in;
   logic [CW-1:0]         lcur_ff, lcur_in;
   logic [CW-1:0]         rcur_ff, rcur_in;
   logic signed [31:0]    rd_left_ff, rd_right_ff;
   logic signed [31:0]    store [MAX_ITEMS];
   logic                  rsp_valid_ff, rsp_valid_in;
   kcm_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0]         lcur_dec;
   logic [AW-1:0]         left_addr, right_addr;
   logic                  has_left, has_right, take_left, out_free, emit;
   logic [32:0]           diff_left, diff_right;

   // Read addresses follow the cursors; an empty side reads entry 0.
   assign lcur_dec   = lcur_ff - 1'b1;
   assign has_left   = (lcur_ff != '0);
   assign has_right  = (rcur_ff < size_ff);
   assign left_addr  = has_left ? lcur_dec[AW-1:0] : '0;
   assign right_addr = has_right ? rcur_ff[AW-1:0] : '0;

   // Set memory: one write port from the chain drain, two registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_left_ff  <= store[left_addr];
      rd_right_ff <= store[right_addr];
   end

   // Distances of both candidates; they always fit in 32 unsigned bits.
   assign diff_left  = {median[31], median} - {rd_left_ff[31], rd_left_ff};
   assign diff_right = {rd_right_ff[31], rd_right_ff} - {median[31], median};

   always_comb begin
      if (!has_left) begin
         take_left = 1'b0;
      end else if (!has_right) begin
         take_left = 1'b1;
      end else begin
         take_left = (diff_left[31:0] <= diff_right[31:0]);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == ST_PICK) && out_free;

   // Walk control: fetch the two candidates, then pick one per result beat.
   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      remain_in   = remain_ff;
      lcur_in     = lcur_ff;
      rcur_in     = rcur_ff;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               size_in   = set_size;
               remain_in = take_count;
               lcur_in   = set_size >> 1;
               rcur_in   = (set_size >> 1) + 1'b1;
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (out_free) begin
               if (take_left) begin
                  rsp_data_in.near_value = rd_left_ff;
                  rsp_data_in.gap        = diff_left[31:0];
                  lcur_in                = lcur_dec;
               end else begin
                  rsp_data_in.near_value = rd_right_ff;
                  rsp_data_in.gap        = diff_right[31:0];
                  rcur_in                = rcur_ff + 1'b1;
               end
               rsp_data_in.run_end = (remain_ff == 1);
               remain_in           = remain_ff - 1'b1;
               state_in            = (remain_ff == 1) ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register holds a stalled beat.
   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      lcur_ff     <= lcur_in;
      rcur_ff     <= rcur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A pick always has at least one candidate left.
   a_pick_has_candidate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> (has_left || has_right))
      else $error("pick with both cursors exhausted");

   // The memory is never rewritten during a walk.
   a_no_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("memory write during result walk");

   // A new walk is launched only from idle.
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("walk started while busy");

   // A walk in progress always has results left to give.
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (remain_ff != '0))
      else $error("walk active with no results left");

   // The last beat of a walk returns the engine to idle.
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && (remain_ff == 1)) |=> (state_ff == ST_IDLE))
      else $error("walk did not end after its last beat");

endmodule

// ===== hw/rtl/k_closest_to_median_top.sv =====
// Top level: sorting insertion chain, set close and drain control.
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     kcm_pkg::req_data_type
//   rsp_      out        rsp_valid / rsp_stall     kcm_pkg::rsp_data_type
//   csr_      in         csr_wr_en                 csr_wr_data (nearest count)
//
// Load takes one beat per cycle, stalled while a set drains; the insertion chain
// sorts as values arrive. A closed set of n values with a nonzero count drains
// its n cells into the set memory, one per cycle, then each result takes a memory
// read, then compare and output. The next set loads during the result walk;
// its drain waits until the walk ends. Reset (synchronous) empties the chain,
// idles the walk and sets the nearest count to 1. A stalled result holds.
`timescale 1ns / 1ps

module k_closest_to_median_top #(
   parameter int MAX_ITEMS = kcm_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  kcm_pkg::req_data_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output kcm_pkg::rsp_data_type         rsp_data,
   input  logic                          csr_wr_en,
   input  logic [kcm_pkg::COUNT_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                        state_ff, state_in;
   logic [kcm_pkg::COUNT_W-1:0] count_ff;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [CW-1:0]               size_ff, size_in;
   logic [CW-1:0]               take_ff, take_in;
   logic [CW-1:0]               drain_idx_ff, drain_idx_in;
   logic signed [31:0]          median_ff, median_in;

   logic signed [31:0]          cell_value [MAX_ITEMS];
   logic                        cell_valid [MAX_ITEMS];
   logic                        cell_gt    [MAX_ITEMS];
   kcm_pkg::cell_ctrl_type      ctrl;

   logic                        req_accept, set_close, chain_full;
   logic                        drain_step, drain_last, sel_start, sel_busy;
   logic [CW-1:0]               size_close, take_close;
   logic [31:0]                 size_ext, count_ext, take_ext;

   // Nearest-count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= kcm_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Input beats are taken only while loading.
   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign set_close  = req_accept && req_data.set_end;
   assign chain_full = cell_valid[MAX_ITEMS-1];

   // Set size at close, and the count clamped to size minus one.
   assign size_close = chain_full ? fill_ff : fill_ff + 1'b1;
   assign size_ext   = 32'(size_close);
   assign count_ext  = 32'(count_ff);
   assign take_ext   = (count_ext > size_ext - 1) ? size_ext - 1 : count_ext;
   assign take_close = take_ext[CW-1:0];

   // Drain moves one cell per cycle once the walk of the previous set is over.
   assign drain_step = (state_ff == ST_DRAIN) && !sel_busy;
   assign drain_last = (drain_idx_ff == size_ff - 1'b1);
   assign sel_start  = drain_step && drain_last;

   assign ctrl.load  = req_accept && !chain_full;
   assign ctrl.drain = drain_step;
   assign ctrl.clear = set_close && (take_close == '0);

   // Load and drain sequencing.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      size_in      = size_ff;
      take_in      = take_ff;
      drain_idx_in = drain_idx_ff;
      median_in    = median_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (set_close) begin
               fill_in = '0;
               if (take_close != '0) begin
                  size_in      = size_close;
                  take_in      = take_close;
                  drain_idx_in = '0;
                  state_in     = ST_DRAIN;
               end
            end else if (ctrl.load) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_step) begin
               if (drain_idx_ff == (size_ff >> 1)) begin
                  median_in = cell_value[0];
               end
               drain_idx_in = drain_idx_ff + 1'b1;
               if (drain_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      take_ff      <= take_in;
      drain_idx_ff <= drain_idx_in;
      median_ff    <= median_in;
   end

   // Insertion chain: each cell sees its left and right neighbors.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [31:0] prev_value, next_value;
      logic               prev_valid, prev_gt, next_valid;

      if (i == 0) begin : g_head
         assign prev_value = '0;
         assign prev_valid = 1'b1;
         assign prev_gt    = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      kcm_sort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_data.sample_value),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_gt    (prev_gt),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .gt         (cell_gt[i])
      );
   end

   // Set memory and result walk.
   kcm_select #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (drain_step),
      .wr_addr    (drain_idx_ff[AW-1:0]),
      .wr_data    (cell_value[0]),
      .start      (sel_start),
      .set_size   (size_ff),
      .take_count (take_ff),
      .median     (median_in),
      .busy       (sel_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== verif/tb.sv =====
// Testbench for the k-closest-to-median block: directed sets, random sets, result checking.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_ITEMS = kcm_pkg::MAX_ITEMS_DEFAULT;
   localparam int ITEM_TARGET = 430;
   // Longest quiet time after the last result: a full drain plus a few result walks.
   localparam int SETTLE_CYCLES = 2 * MAX_ITEMS + 40;
   localparam int CYCLE_LIMIT = 1000000;

   typedef logic [kcm_pkg::COUNT_W-1:0] count_type;

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam count_type COUNT_NONE = '0;
   localparam count_type COUNT_FULL = '1;

   typedef enum int {VALS_WIDE, VALS_NARROW, VALS_EXTREME} value_kind_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   kcm_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   kcm_pkg::rsp_data_type rsp_data;
   logic                  csr_wr_en = 1'b0;
   count_type             csr_wr_data = '0;

   // Predictor state: the values of the open set, kept ascending, and the count setting.
   logic signed [31:0]    held_vals [MAX_ITEMS];
   int unsigned           held_count = 0;
   count_type             count_setting = kcm_pkg::COUNT_RESET;
   kcm_pkg::rsp_data_type expected_nearest [$];

   int                    mismatch_count = 0;
   int                    items_sent = 0;
   int                    cycle_count = 0;
   int                    burst_left = 0;
   bit                    sender_gaps_on = 1'b1;
   stall_kind_type        stall_mode = STALL_NONE;
   int                    stall_left = 0;

   k_closest_to_median_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Insert one accepted beat into the sorted set; on set end, queue the nearest values.
   function automatic void predict_nearest(input kcm_pkg::req_data_type beat);
      int unsigned pos, n, mid, k, lo, hi, i;
      logic signed [31:0] median, v;
      logic [31:0] gl, gr, g;
      logic take_left;
      kcm_pkg::rsp_data_type e;
      if (held_count < MAX_ITEMS) begin
         pos = held_count;
         while (pos > 0 && held_vals[pos - 1] > beat.sample_value) begin
            held_vals[pos] = held_vals[pos - 1];
            pos--;
         end
         held_vals[pos] = beat.sample_value;
         held_count++;
      end
      if (!beat.set_end)
         return;
      n = held_count;
      held_count = 0;
      if (n == 0)
         return;
      mid = n / 2;
      median = held_vals[mid];
      k = 32'(count_setting);
      if (k > n - 1)
         k = n - 1;
      lo = mid;
      hi = mid + 1;
      // Walk outward from the median; on equal distance the lower neighbor wins.
      for (i = 0; i < k; i++) begin
         if (lo == 0) begin
            take_left = 1'b0;
         end else if (hi >= n) begin
            take_left = 1'b1;
         end else begin
            gl = median - held_vals[lo - 1];
            gr = held_vals[hi] - median;
            take_left = (gl <= gr);
         end
         if (take_left) begin
            v = held_vals[lo - 1];
            g = median - v;
            lo--;
         end else begin
            v = held_vals[hi];
            g = v - median;
            hi++;
         end
         e.near_value = v;
         e.gap = g;
         e.run_end = (i + 1 == k);
         expected_nearest.push_back(e);
      end
   endfunction

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin : check_results
      kcm_pkg::rsp_data_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_nearest.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat value %0d gap %0d end %0b",
               rsp_data.near_value, rsp_data.gap, rsp_data.run_end));
         end else begin
            want = expected_nearest.pop_front();
            if (rsp_data.near_value !== want.near_value)
               report_mismatch($sformatf("near_value %0d, expected %0d",
                  rsp_data.near_value, want.near_value));
            if (rsp_data.gap !== want.gap)
               report_mismatch($sformatf("gap %0d, expected %0d", rsp_data.gap, want.gap));
            if (rsp_data.run_end !== want.run_end)
               report_mismatch($sformatf("run_end %0b, expected %0b",
                  rsp_data.run_end, want.run_end));
         end
      end
   end

   // Receiver backpressure: switch between randomly chosen stall patterns.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (cycle_count % 7 < 3);
         end
      endcase
   end

   // Send one beat, with random gaps between bursts, and predict it once accepted.
   task automatic send_sample(input logic signed [31:0] sample, input logic last);
      kcm_pkg::req_data_type beat;
      int gap_len;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_len = sender_gaps_on ? $urandom_range(0, 6) : 0;
         if (gap_len > 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      beat.sample_value = sample;
      beat.set_end = last;
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
      predict_nearest(beat);
   endtask

   // Stop sending and wait until every queued result has arrived and the block is quiet.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_nearest.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_nearest_count(input count_type count);
      wait_results_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      count_setting = count;
   endtask

   function automatic logic signed [31:0] random_sample(input value_kind_type kind);
      logic signed [31:0] r;
      case (kind)
         VALS_NARROW: begin
            r = $urandom_range(0, 16);
            r = r - 8;
         end
         VALS_EXTREME: begin
            case ($urandom_range(0, 6))
               0: r = VALUE_MIN;
               1: r = VALUE_MAX;
               2: r = VALUE_MIN + 1;
               3: r = VALUE_MAX - 1;
               4: r = 0;
               5: r = -1;
               default: r = $urandom;
            endcase
         end
         default: begin
            r = $urandom;
         end
      endcase
      return r;
   endfunction

   task automatic send_random_set(input int size, input value_kind_type kind);
      for (int i = 0; i < size; i++)
         send_sample(random_sample(kind), i == size - 1);
   endtask

   // The count after reset is one: a single nearest value, tie going to the lower one.
   task automatic test_reset_count();
      send_sample(5, 1'b0);
      send_sample(-3, 1'b0);
      send_sample(9, 1'b0);
      send_sample(7, 1'b1);
   endtask

   // Full-scale values, where the distance reaches the top of its range.
   task automatic test_field_extremes();
      write_nearest_count(COUNT_FULL);
      send_sample(VALUE_MAX, 1'b0);
      send_sample(VALUE_MIN, 1'b1);
      send_sample(VALUE_MIN, 1'b0);
      send_sample(VALUE_MAX, 1'b0);
      send_sample(0, 1'b1);
      send_sample(32'sh5555_5555, 1'b0);
      send_sample(32'shAAAA_AAAA, 1'b1);
   endtask

   // Copies of the median are emitted with zero distance; equal distances pick the lower.
   task automatic test_ties_and_duplicates();
      send_sample(3, 1'b0);
      send_sample(3, 1'b0);
      send_sample(1, 1'b0);
      send_sample(3, 1'b0);
      send_sample(5, 1'b1);
      send_sample(5, 1'b0);
      send_sample(1, 1'b0);
      send_sample(3, 1'b1);
   endtask

   // A set of one value and a zero count both produce no results.
   task automatic test_nothing_emitted();
      send_sample(42, 1'b1);
      write_nearest_count(COUNT_NONE);
      send_sample(1, 1'b0);
      send_sample(2, 1'b0);
      send_sample(3, 1'b1);
   endtask

   // More values than the store holds: the extra ones are dropped, the end still closes.
   task automatic test_store_full();
      write_nearest_count(COUNT_FULL);
      send_random_set(MAX_ITEMS + $urandom_range(1, 4), VALS_WIDE);
      send_random_set(MAX_ITEMS, VALS_NARROW);
   endtask

   // The sender holds off until every expected result has come back.
   task automatic test_pause_for_results();
      write_nearest_count(6'd3);
      send_random_set(9, VALS_NARROW);
      wait_results_drained();
      send_random_set(7, VALS_WIDE);
   endtask

   // Random phases: a count setting, then a few sets of random size and content.
   task automatic test_random_sets();
      count_type count;
      int size;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0: count = COUNT_NONE;
            1: count = COUNT_FULL;
            2: count = count_type'($urandom_range(0, 63));
            default: count = count_type'($urandom_range(1, 8));
         endcase
         write_nearest_count(count);
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 6)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_ITEMS)
                                               : $urandom_range(1, 12);
            send_random_set(size, value_kind_type'($urandom_range(0, 2)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_count();
      test_field_extremes();
      test_ties_and_duplicates();
      test_nothing_emitted();
      test_store_full();
      test_pause_for_results();
      test_random_sets();

      wait_results_drained();
      if (expected_nearest.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
            expected_nearest.size()));
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/kcm_pkg.sv
hw/rtl/kcm_sort_cell.sv
hw/rtl/kcm_select.sv
hw/rtl/k_closest_to_median_top.sv
verif/tb.sv
